// ----- design/moving_window_max_min_count_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef MOVING_WINDOW_MAX_MIN_COUNT_CORE_ASSERT_SVH
`define MOVING_WINDOW_MAX_MIN_COUNT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MWMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mwmm_pkg.sv -----
package mwmm_pkg;

  // Default window depth and fixed field widths
  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int MODE_W         = 2;
  localparam int WSIZE_W        = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 7;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_MAX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WSIZE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_ok;
    logic                       series_start;
  } in_payload_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_value;
    logic                       result_ok;
  } out_payload_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // transaction accepted: write sample, load scan
    logic issue_rd;  // read one window entry
    logic load_out;  // move result into output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_zero; // nothing to scan for the arriving sample
    logic last_rd;   // one read left
    logic out_free;  // output register can take a result
  } dp_stat_t;

endpackage

// ----- design/mwmm_stream_if.sv -----
interface mwmm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/moving_window_max_min_count_core.sv -----
// Each input transaction writes its sample, then reads the newest min(N, L) window entries,
// one per cycle, through the single read port of the sample memory and folds them in; the
// result then goes to the output register once that is free. N is window_size capped at
// WINDOW_MAX, L the samples seen in the current series. A new input waits for that load.
// Reset (rst_n, synchronous, active low) clears control, mode and window_size;
// the sample memory needs no clearing pass, entries older than the series are skipped.
module moving_window_max_min_count_core #(
  parameter int WINDOW_MAX = mwmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mwmm_stream_if.sink                     in_ch,
  mwmm_stream_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [mwmm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mwmm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mwmm_pkg::ctl_cmd_t cmd;
  mwmm_pkg::dp_stat_t stat;

  // Sequencer
  mwmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // Window memory, compare unit and output register
  mwmm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_ch.payload),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.payload),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ----- design/mwmm_ctrl.sv -----
module mwmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  mwmm_pkg::dp_stat_t stat,
  output logic              in_ready,
  output mwmm_pkg::ctl_cmd_t cmd
);

  mwmm_pkg::ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwmm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.issue_rd = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      mwmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = stat.scan_zero ? mwmm_pkg::ST_DONE : mwmm_pkg::ST_SCAN;
        end
      end
      mwmm_pkg::ST_SCAN: begin
        cmd.issue_rd = 1'b1;
        if (stat.last_rd) begin
          state_nxt = mwmm_pkg::ST_DRAIN;
        end
      end
      // last read data is folded in here
      mwmm_pkg::ST_DRAIN: begin
        state_nxt = mwmm_pkg::ST_DONE;
      end
      mwmm_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = mwmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwmm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mwmm_dp.sv -----
module mwmm_dp #(
  parameter int WINDOW_MAX = mwmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mwmm_pkg::ctl_cmd_t                  cmd,
  output mwmm_pkg::dp_stat_t                  stat,
  input  mwmm_pkg::in_payload_t               in_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output mwmm_pkg::out_payload_t              out_data,
  input  logic                                cfg_we,
  input  logic [mwmm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mwmm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CW    = (LEN_W > mwmm_pkg::WSIZE_W) ? LEN_W : mwmm_pkg::WSIZE_W;
  localparam int SW    = mwmm_pkg::SAMPLE_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WINDOW_MAX);
  localparam logic [CW-1:0]    WMAX_C   = CW'(WINDOW_MAX);

  // Sample memory: {sample_ok, sample}, written at the newest slot
  logic [SW:0] mem [WINDOW_MAX];

  logic [mwmm_pkg::MODE_W-1:0]  mode_r;
  logic [mwmm_pkg::WSIZE_W-1:0] wsize_r;
  logic [PTR_W-1:0]             wptr_r, new_ptr, rd_addr_r;
  logic [LEN_W-1:0]             len_r, len_new, remain_r, cnt_r;
  logic [CW-1:0]                n_cap, len_ext, scan_n;
  logic                         rd_vld_r;
  logic [SW:0]                  rd_data_r;
  logic                         have_r;
  logic signed [SW-1:0]         best_r, rd_sample;
  logic                         better;
  logic                         out_valid_r;
  mwmm_pkg::out_payload_t       out_data_r, result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      wsize_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        mwmm_pkg::CFG_MODE:  mode_r  <= cfg_wdata[mwmm_pkg::MODE_W-1:0];
        mwmm_pkg::CFG_WSIZE: wsize_r <= cfg_wdata[mwmm_pkg::WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Write slot, series length and scan length for the arriving sample
  always_comb begin
    new_ptr = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    if (in_data.series_start) begin
      len_new = LEN_W'(1);
    end else if (len_r == LEN_FULL) begin
      len_new = len_r;
    end else begin
      len_new = len_r + 1'b1;
    end
    n_cap   = (CW'(wsize_r) > WMAX_C) ? WMAX_C : CW'(wsize_r);
    len_ext = CW'(len_new);
    scan_n  = (n_cap > len_ext) ? len_ext : n_cap;
  end

  assign stat.scan_zero = (scan_n == '0);
  assign stat.last_rd   = (remain_r == LEN_W'(1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mem[new_ptr] <= {in_data.sample_ok, in_data.sample};
    end
    if (cmd.issue_rd) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  // Pointers and scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      len_r    <= '0;
      rd_addr_r <= '0;
      remain_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue_rd;
      if (cmd.start) begin
        wptr_r    <= new_ptr;
        len_r     <= len_new;
        rd_addr_r <= new_ptr;
        remain_r  <= scan_n[LEN_W-1:0];
      end else if (cmd.issue_rd) begin
        rd_addr_r <= (rd_addr_r == '0) ? PTR_LAST : rd_addr_r - 1'b1;
        remain_r  <= remain_r - 1'b1;
      end
    end
  end

  // Compare against running best
  assign rd_sample = $signed(rd_data_r[SW-1:0]);
  always_comb begin
    case (mode_r)
      mwmm_pkg::MODE_MAX: better = rd_sample > best_r;
      mwmm_pkg::MODE_MIN: better = rd_sample < best_r;
      default:            better = 1'b0;
    endcase
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      have_r <= 1'b0;
      cnt_r  <= '0;
    end else if (rd_vld_r && rd_data_r[SW]) begin
      have_r <= 1'b1;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && rd_data_r[SW] && (!have_r || better)) begin
      best_r <= rd_sample;
    end
  end

  // Result select
  always_comb begin
    result.result_value = '0;
    result.result_ok    = 1'b0;
    case (mode_r)
      mwmm_pkg::MODE_COUNT: begin
        result.result_value = SW'(cnt_r);
        result.result_ok    = 1'b1;
      end
      mwmm_pkg::MODE_MAX, mwmm_pkg::MODE_MIN: begin
        if (have_r) begin
          result.result_value = best_r;
          result.result_ok    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/mwmm_checker.sv -----
`include "moving_window_max_min_count_core_assert.svh"

module mwmm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [mwmm_pkg::SAMPLE_W-1:0] result_value,
  input logic                            result_ok,
  input logic                            cfg_we,
  input logic [mwmm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input logic [mwmm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]                  pend_r;
  logic [mwmm_pkg::MODE_W-1:0] mode_r;
  logic                        in_hs, out_hs;

  assign in_hs  = in_valid && in_ready;
  assign out_hs = out_valid && out_ready;

  // Transactions in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_hs) - 2'(out_hs);
    end
  end

  // Mirror of the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mwmm_pkg::MODE_MAX;
    end else if (cfg_we && cfg_idx == mwmm_pkg::CFG_MODE) begin
      mode_r <= cfg_wdata[mwmm_pkg::MODE_W-1:0];
    end
  end

  `MWMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(result_ok), "stalled result changed")
  `MWMM_ASSERT_NOW(a_no_extra, out_valid, pend_r != 2'd0, "result without input transaction")
  `MWMM_ASSERT_NOW(a_full_stall, pend_r == 2'd2, !in_ready, "input taken with two in flight")
  `MWMM_ASSERT_NOW(a_count_ok, out_valid && mode_r == mwmm_pkg::MODE_COUNT, result_ok, "count result not ok")
  `MWMM_ASSERT_NOW(a_empty_zero, out_valid && !result_ok, result_value == '0, "undefined result not zero")

endmodule

bind moving_window_max_min_count_core mwmm_checker u_mwmm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.payload.result_value),
  .result_ok    (out_ch.payload.result_ok),
  .cfg_we       (cfg_we),
  .cfg_idx      (cfg_idx),
  .cfg_wdata    (cfg_wdata)
);
